[rtl/abps_pkg.sv]
// Shared types, codes and the segment pattern tables for the buzzer sequencer.
// Used by every module under rtl; depends on nothing.
package abps_pkg;

    localparam int SEGMENT_CAPACITY = 16;
    localparam int SEG_IDX_W        = $clog2(SEGMENT_CAPACITY);
    localparam int SEG_CNT_W        = 5;
    localparam int SEG_LEN_W        = 10;
    localparam int TIME_W           = 32;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;

    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_ALARM = 2'd1;
    localparam logic [1:0] CLASS_CROSS = 2'd2;

    localparam logic [SEG_LEN_W-1:0] LEN_ALARM = 10'd100;
    localparam logic [SEG_LEN_W-1:0] LEN_SHORT = 10'd150;
    localparam logic [SEG_LEN_W-1:0] LEN_OPEN_ON  = 10'd300;
    localparam logic [SEG_LEN_W-1:0] LEN_OPEN_OFF = 10'd200;
    localparam logic [SEG_LEN_W-1:0] LEN_SPLIT = 10'd500;

    localparam logic [SEG_CNT_W-1:0] ALARM_PULSES = 5'd5;
    localparam logic [SEG_CNT_W-1:0] SHORT_PULSES = 5'd3;
    localparam logic [SEG_CNT_W-1:0] OPEN_SEGS    = 5'd3;

    typedef enum logic [2:0] {
        PAT_NONE,
        PAT_ALARM,
        PAT_SHORT,
        PAT_OPEN,
        PAT_SHORT_OPEN
    } pattern_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        result_class;
        logic              has_unexpected;
        logic              has_missing;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic                 level;
        logic [SEG_LEN_W-1:0] length;
    } segment_t;

    // Number of segments a pattern builds before the capacity cut.
    function automatic logic [SEG_CNT_W-1:0] pattern_count(input pattern_t kind);
        logic [SEG_CNT_W-1:0] cnt;
        case (kind)
            PAT_ALARM:      cnt = (ALARM_PULSES << 1) - 5'd1;
            PAT_SHORT:      cnt = (SHORT_PULSES << 1) - 5'd1;
            PAT_OPEN:       cnt = OPEN_SEGS;
            PAT_SHORT_OPEN: cnt = (SHORT_PULSES << 1) + OPEN_SEGS;
            default:        cnt = '0;
        endcase
        return cnt;
    endfunction

    // Segment count after dropping everything past the capacity.
    function automatic logic [SEG_CNT_W-1:0] pattern_total(input pattern_t kind);
        logic [SEG_CNT_W-1:0] cnt;
        cnt = pattern_count(kind);
        if (cnt > SEG_CNT_W'(SEGMENT_CAPACITY))
        begin
            cnt = SEG_CNT_W'(SEGMENT_CAPACITY);
        end
        return cnt;
    endfunction

    // Open pattern, alone or after the short pulses: on, off, on.
    function automatic segment_t open_seg(input logic [SEG_IDX_W-1:0] idx);
        segment_t seg;
        seg.level  = (idx != SEG_IDX_W'(1));
        seg.length = seg.level ? LEN_OPEN_ON : LEN_OPEN_OFF;
        return seg;
    endfunction

    function automatic segment_t pattern_segment(input pattern_t kind,
                                                 input logic [SEG_IDX_W-1:0] idx);
        segment_t seg;
        logic [SEG_IDX_W-1:0] short_segs;
        short_segs = SEG_IDX_W'((SHORT_PULSES << 1) - 5'd1);
        seg.level  = 1'b0;
        seg.length = '0;
        case (kind)
            PAT_ALARM:
            begin
                seg.level  = ~idx[0];
                seg.length = LEN_ALARM;
            end
            PAT_SHORT:
            begin
                seg.level  = ~idx[0];
                seg.length = LEN_SHORT;
            end
            PAT_OPEN:
            begin
                seg = open_seg(idx);
            end
            PAT_SHORT_OPEN:
            begin
                if (idx < short_segs)
                begin
                    seg.level  = ~idx[0];
                    seg.length = LEN_SHORT;
                end
                else if (idx == short_segs)
                begin
                    seg.level  = 1'b0;
                    seg.length = LEN_SPLIT;
                end
                else
                begin
                    seg = open_seg(idx - short_segs - SEG_IDX_W'(1));
                end
            end
            default:
            begin
                seg.level  = 1'b0;
                seg.length = '0;
            end
        endcase
        return seg;
    endfunction

endpackage

[rtl/abps_in_stage.sv]
// Input register of the buzzer sequencer: holds one transfer until the core takes it.
// Depends on abps_pkg for the item type.
module abps_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  abps_pkg::item_t in_item,
    input  logic           take,
    output logic           held_valid,
    output abps_pkg::item_t held_item
);
    import abps_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept whenever the slot is empty or drains this cycle.
    assign in_ready   = ~valid_reg | take;
    assign valid_next = in_valid | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[rtl/abps_core.sv]
// Sequencer state and result register: classifies start items, steps segments on ticks, clears on silence.
// Depends on abps_pkg for codes, item type and the pattern tables.
module abps_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  abps_pkg::item_t item,
    output logic            take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            buzzer_on,
    output logic            pattern_active
);
    import abps_pkg::*;

    pattern_t             kind_reg, kind_next;
    logic [SEG_CNT_W-1:0] total_reg, total_next;
    logic [SEG_CNT_W-1:0] pos_reg, pos_next;
    logic [TIME_W-1:0]    deadline_reg, deadline_next;
    logic                 drive_reg, drive_next;
    logic                 out_valid_reg;
    logic                 buzzer_reg;
    logic                 active_reg;

    pattern_t             start_kind;
    logic                 shorted;
    logic [SEG_CNT_W-1:0] start_total;
    logic [SEG_CNT_W-1:0] step_pos;
    logic [TIME_W-1:0]    elapsed;
    segment_t             first_seg;
    segment_t             step_seg;

    assign take = item_valid & (~out_valid_reg | out_ready);

    always_comb
    begin
        shorted = item.has_unexpected | (item.result_class == CLASS_CROSS);
        if (item.result_class == CLASS_NONE)
        begin
            start_kind = PAT_NONE;
        end
        else if (item.result_class == CLASS_ALARM)
        begin
            start_kind = PAT_ALARM;
        end
        else if (shorted && item.has_missing)
        begin
            start_kind = PAT_SHORT_OPEN;
        end
        else if (shorted)
        begin
            start_kind = PAT_SHORT;
        end
        else if (item.has_missing)
        begin
            start_kind = PAT_OPEN;
        end
        else
        begin
            start_kind = PAT_NONE;
        end
    end

    assign start_total = pattern_total(start_kind);
    assign first_seg   = pattern_segment(start_kind, '0);
    assign step_pos    = pos_reg + SEG_CNT_W'(1);
    assign step_seg    = pattern_segment(kind_reg, step_pos[SEG_IDX_W-1:0]);
    assign elapsed     = item.now_ms - deadline_reg;

    always_comb
    begin
        kind_next     = kind_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        deadline_next = deadline_reg;
        drive_next    = drive_reg;
        unique case (item.action)
            ACT_TICK:
            begin
                // Deadline reached when the wrap-safe difference is not negative.
                if (total_reg != '0 && !elapsed[TIME_W-1])
                begin
                    pos_next = step_pos;
                    if (step_pos >= total_reg)
                    begin
                        total_next = '0;
                        drive_next = 1'b0;
                    end
                    else
                    begin
                        drive_next    = step_seg.level;
                        deadline_next = item.now_ms + TIME_W'(step_seg.length);
                    end
                end
            end
            ACT_START:
            begin
                kind_next  = start_kind;
                total_next = start_total;
                pos_next   = '0;
                if (start_total == '0)
                begin
                    drive_next = 1'b0;
                end
                else
                begin
                    drive_next    = first_seg.level;
                    deadline_next = item.now_ms + TIME_W'(first_seg.length);
                end
            end
            ACT_SILENCE:
            begin
                drive_next = 1'b0;
                total_next = '0;
                pos_next   = '0;
            end
            default:
            begin
                // Unused action code: hold state, report current levels.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= PAT_NONE;
            total_reg     <= '0;
            pos_reg       <= '0;
            deadline_reg  <= '0;
            drive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                kind_reg     <= kind_next;
                total_reg    <= total_next;
                pos_reg      <= pos_next;
                deadline_reg <= deadline_next;
                drive_reg    <= drive_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buzzer_reg <= drive_next;
            active_reg <= (total_next != '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign buzzer_on      = buzzer_reg;
    assign pattern_active = active_reg;

endmodule

[rtl/alert_buzzer_pattern_sequencer.sv]
// Top level of the alert buzzer pattern sequencer.
// Depends on abps_pkg, abps_in_stage and abps_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: an action
//   (tick, start pattern, silence), the test result class with its short and
//   open flags, and the current millisecond time now_ms.
//   Output channel (out_valid/out_ready) returns one result per input item:
//   buzzer_on, the drive level after the item, and pattern_active, high while
//   a segment list is still playing.
//   Path: an item passes the input register, then the state update into the
//   result register; out_valid rises once the result register is loaded.
//   Throughput: one item per cycle while out_ready stays high; the state update is a single pass of
//   table lookup, one 32-bit add and one 32-bit subtract for the deadline.
//   Stall: while out_ready is low the result is held and one further item
//   waits in the input register; in_ready then drops until the result leaves.
//   Reset: rst_n low clears the segment list and both channels, not buzzer_on or pattern_active.
module alert_buzzer_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [1:0]  result_class,
    input  logic        has_unexpected,
    input  logic        has_missing,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        buzzer_on,
    output logic        pattern_active
);
    import abps_pkg::*;

    item_t in_item;
    item_t held_item;
    logic  held_valid;
    logic  take;

    assign in_item.action         = action;
    assign in_item.result_class   = result_class;
    assign in_item.has_unexpected = has_unexpected;
    assign in_item.has_missing    = has_missing;
    assign in_item.now_ms         = now_ms;

    abps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    abps_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (held_valid),
        .item           (held_item),
        .take           (take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .buzzer_on      (buzzer_on),
        .pattern_active (pattern_active)
    );

endmodule

[sim/alert_buzzer_pattern_sequencer_tb.sv]
// Testbench for alert_buzzer_pattern_sequencer: directed and random item streams,
// predicted by a scoreboard class and compared result by result.
// Depends on abps_pkg and the RTL under rtl.
module alert_buzzer_pattern_sequencer_tb;
    import abps_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] CLASS_OTHER = 2'd3;
    localparam int RANDOM_PER_PHASE    = 400;
    localparam int LONG_HOLD_CYCLES    = 400;

    typedef struct packed {
        logic buzzer;
        logic active;
    } buzz_result_t;

    // Tracks the segment list and drive level, queues the result of each transfer.
    class buzz_scoreboard;
        localparam int CAP         = 16;
        localparam logic [9:0] MS_ALARM    = 10'd100;
        localparam logic [9:0] MS_SHORT    = 10'd150;
        localparam logic [9:0] MS_OPEN_ON  = 10'd300;
        localparam logic [9:0] MS_OPEN_OFF = 10'd200;
        localparam logic [9:0] MS_GAP      = 10'd500;

        logic        seg_lvl[CAP];
        logic [9:0]  seg_ms[CAP];
        logic [4:0]  seg_count;
        logic [4:0]  seg_idx;
        logic [31:0] due_ms;
        logic        drive;
        buzz_result_t pending_results[$];
        int errors;

        function new();
            for (int i = 0; i < CAP; i++)
            begin
                seg_lvl[i] = 1'b0;
                seg_ms[i]  = '0;
            end
            seg_count = '0;
            seg_idx   = '0;
            due_ms    = '0;
            drive     = 1'b0;
            errors    = 0;
        endfunction

        function void add_segment(logic lvl, logic [9:0] ms);
            if (seg_count >= 5'(CAP))
            begin
                return;
            end
            seg_lvl[seg_count[3:0]] = lvl;
            seg_ms[seg_count[3:0]]  = ms;
            seg_count = seg_count + 5'd1;
        endfunction

        function void add_beeps(int count, logic [9:0] ms);
            for (int k = 0; k < count; k++)
            begin
                add_segment(1'b1, ms);
                if (k + 1 < count)
                begin
                    add_segment(1'b0, ms);
                end
            end
        endfunction

        function void open_segment(logic [31:0] now);
            if (seg_idx >= 5'(CAP))
            begin
                seg_count = '0;
                drive     = 1'b0;
                return;
            end
            drive  = seg_lvl[seg_idx[3:0]];
            due_ms = now + 32'(seg_ms[seg_idx[3:0]]);
        endfunction

        function void build_pattern(logic [1:0] cls, logic unexp, logic miss, logic [31:0] now);
            logic shorted;
            seg_count = '0;
            seg_idx   = '0;
            if (cls == CLASS_NONE)
            begin
                drive = 1'b0;
                return;
            end
            if (cls == CLASS_ALARM)
            begin
                add_beeps(5, MS_ALARM);
            end
            else
            begin
                shorted = unexp || (cls == CLASS_CROSS);
                if (shorted)
                begin
                    add_beeps(3, MS_SHORT);
                end
                if (shorted && miss)
                begin
                    add_segment(1'b0, MS_GAP);
                end
                if (miss)
                begin
                    add_segment(1'b1, MS_OPEN_ON);
                    add_segment(1'b0, MS_OPEN_OFF);
                    add_segment(1'b1, MS_OPEN_ON);
                end
            end
            if (seg_count == '0)
            begin
                drive = 1'b0;
                return;
            end
            open_segment(now);
        endfunction

        function void advance_on_tick(logic [31:0] now);
            logic [31:0] diff;
            if (seg_count == '0)
            begin
                return;
            end
            diff = now - due_ms;
            // Deadline not reached while the wrap-safe difference is negative.
            if (diff[31])
            begin
                return;
            end
            seg_idx = seg_idx + 5'd1;
            if (seg_idx >= seg_count)
            begin
                seg_count = '0;
                drive     = 1'b0;
                return;
            end
            open_segment(now);
        endfunction

        function void note_item(logic [1:0] act, logic [1:0] cls, logic unexp, logic miss,
                                logic [31:0] now);
            buzz_result_t res;
            case (act)
                ACT_TICK:    advance_on_tick(now);
                ACT_START:   build_pattern(cls, unexp, miss, now);
                ACT_SILENCE:
                begin
                    drive     = 1'b0;
                    seg_count = '0;
                    seg_idx   = '0;
                end
                default:     ;
            endcase
            res.buzzer = drive;
            res.active = (seg_count != '0);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic buzzer, logic active);
            buzz_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result: buzzer_on=%b pattern_active=%b", buzzer, active);
                end
                return;
            end
            want = pending_results.pop_front();
            if (buzzer !== want.buzzer || active !== want.active)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: buzzer_on exp %b got %b, pattern_active exp %b got %b",
                             want.buzzer, buzzer, want.active, active);
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [1:0]  result_class;
    logic        has_unexpected;
    logic        has_missing;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic        buzzer_on;
    logic        pattern_active;

    buzz_scoreboard sb = new();
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  items_sent     = 0;
    int  hold_left      = 0;
    bit  long_hold_req  = 1'b0;

    alert_buzzer_pattern_sequencer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .result_class   (result_class),
        .has_unexpected (has_unexpected),
        .has_missing    (has_missing),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .buzzer_on      (buzzer_on),
        .pattern_active (pattern_active)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("alert_buzzer_pattern_sequencer_tb NOT OK");
        $finish;
    end

    // Receiver: random stalls, plus a long hold on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(buzzer_on, pattern_active);
        end
    end

    // Offer one item and hold it until the transfer completes.
    task automatic send_item(input logic [1:0] act, input logic [1:0] cls, input logic unexp,
                             input logic miss, input logic [31:0] t);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action         = act;
        result_class   = cls;
        has_unexpected = unexp;
        has_missing    = miss;
        now_ms         = t;
        in_valid       = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_item(act, cls, unexp, miss, t);
        if (act != ACT_UNUSED)
        begin
            items_sent++;
        end
    endtask

    task automatic send_tick(input logic [31:0] t);
        send_item(ACT_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), t);
    endtask

    task automatic send_start(input logic [31:0] t);
        logic [1:0] cls;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            cls = CLASS_NONE;
        end
        else if (pick < 4)
        begin
            cls = CLASS_ALARM;
        end
        else if (pick < 6)
        begin
            cls = CLASS_CROSS;
        end
        else
        begin
            cls = CLASS_OTHER;
        end
        send_item(ACT_START, cls, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
    endtask

    // A start then ticks with noise, time mostly rising; or random items alone.
    task automatic play_sequence();
        logic [31:0] t;
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            t = 32'hFFFF_FFFF - 32'($urandom_range(0, 1500));
        end
        else
        begin
            t = $urandom;
        end
        if (roll >= 90)
        begin
            repeat ($urandom_range(1, 8))
            begin
                send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
            end
            return;
        end
        send_start(t);
        n = $urandom_range(4, 40);
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_item(ACT_SILENCE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), t);
            end
            else if (roll < 6)
            begin
                send_item(ACT_UNUSED, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
            end
            else if (roll < 9)
            begin
                send_start(t);
            end
            else if (roll < 11)
            begin
                t = $urandom;
                send_tick(t);
            end
            else
            begin
                t = t + 32'($urandom_range(0, 200));
                send_tick(t);
            end
        end
    endtask

    initial
    begin
        int target;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_TICK;
        result_class   = CLASS_NONE;
        has_unexpected = 1'b0;
        has_missing    = 1'b0;
        now_ms         = '0;
        repeat (12)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick, unused code, every class, deadline edges, wrap.
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'h0000_0000);
        send_item(ACT_UNUSED,  CLASS_OTHER, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(ACT_START,   CLASS_NONE,  1'b1, 1'b1, 32'd5);
        send_item(ACT_START,   CLASS_ALARM, 1'b0, 1'b0, 32'hFFFF_FFF0);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'h0000_0053);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'h0000_0054);
        send_item(ACT_UNUSED,  CLASS_ALARM, 1'b0, 1'b1, 32'h0000_1000);
        send_item(ACT_START,   CLASS_OTHER, 1'b0, 1'b0, 32'd100);
        send_item(ACT_START,   CLASS_CROSS, 1'b0, 1'b1, 32'd1000);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'd1150);
        send_item(ACT_SILENCE, CLASS_NONE,  1'b0, 1'b0, 32'd1200);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'd5000);
        send_item(ACT_START,   CLASS_OTHER, 1'b1, 1'b0, 32'd0);
        send_item(ACT_START,   CLASS_OTHER, 1'b1, 1'b1, 32'd10);
        send_item(ACT_START,   CLASS_OTHER, 1'b0, 1'b1, 32'd20);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'd320);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'd520);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'd820);
        send_item(ACT_START,   CLASS_CROSS, 1'b1, 1'b0, 32'h7FFF_FFFF);
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'h8000_0095);
        // Far past the deadline in signed terms: still counts as reached.
        send_item(ACT_TICK,    CLASS_NONE,  1'b0, 1'b0, 32'h0000_0000);
        send_item(ACT_SILENCE, CLASS_OTHER, 1'b1, 1'b1, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            // Stall the output for a long stretch while items keep coming.
            if (phase == 0 || phase == 3)
            begin
                long_hold_req = 1'b1;
            end
            target = items_sent + RANDOM_PER_PHASE;
            while (items_sent < target)
            begin
                play_sequence();
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10)
        begin
            @(posedge clk);
        end
        if (sb.errors == 0)
        begin
            $display("alert_buzzer_pattern_sequencer_tb OK");
        end
        else
        begin
            $display("alert_buzzer_pattern_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule
